@@ rtl/core/lrs_pkg.sv @@
package lrs_pkg;

   localparam int CoordWidth = 16;
   localparam int CoefWidth  = 17;
   localparam int ConstWidth = 32;
   localparam int OutWidth   = 32;
   // Numerator magnitude: |c + a*x| < 2^31 + 2^32 < 2^34.
   localparam int NumWidth   = 34;
   localparam int DenWidth   = 17;
   // Rounded quotient before saturation: (2n+d)/(2d) < 2^34.
   localparam int QuoWidth   = 35;
   localparam int AddrWidth  = 4;
   // Control and valid bits ride beside the product, numerator, divider load,
   // divider stage and saturation registers.
   localparam int PipeDepth  = QuoWidth + 4;

   localparam logic [AddrWidth-1:0] AddrXFirst  = 4'd0;
   localparam logic [AddrWidth-1:0] AddrYFirst  = 4'd4;
   localparam logic [AddrWidth-1:0] AddrXSecond = 4'd8;
   localparam logic [AddrWidth-1:0] AddrYSecond = 4'd12;

   typedef struct packed {
      logic signed [CoordWidth-1:0] xl;
      logic signed [CoordWidth-1:0] xh;
      logic signed [CoordWidth-1:0] yl;
      logic signed [CoordWidth-1:0] yh;
   } rect_type;

   typedef struct packed {
      logic                  neg;
      logic [NumWidth-1:0]   num;
      logic [DenWidth-1:0]   den;
   } div_job_type;

   typedef struct packed {
      logic bad;
      logic horiz;
      logic vert;
      logic use_l;
      logic use_t;
      logic use_r;
      logic use_b;
      rect_type rect;
   } ctl_type;

endpackage

@@ rtl/core/lrs_if.sv @@
interface lrs_req_if;
   logic        valid;
   logic        ready;
   logic [16:0] line_a;
   logic [16:0] line_b;
   logic [31:0] line_c;
   modport source (output valid, line_a, line_b, line_c, input ready);
   modport sink (input valid, line_a, line_b, line_c, output ready);
endinterface

interface lrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] seg_x_start;
   logic [31:0] seg_y_start;
   logic [31:0] seg_x_end;
   logic [31:0] seg_y_end;
   logic        bad_line;
   modport source (output valid, seg_x_start, seg_y_start, seg_x_end, seg_y_end,
                   bad_line, input ready);
   modport sink (input valid, seg_x_start, seg_y_start, seg_x_end, seg_y_end,
                 bad_line, output ready);
endinterface

@@ rtl/core/line_to_rectangle_segment_unit.sv @@
// Line to rectangle segment unit.
//
// Each request item carries a line a*x + b*y + c = 0 (line_a, line_b,
// line_c). The unit clips it against the rectangle held in four 16-bit
// registers written over the APB-style csr_ port, and returns one
// response item with the two segment ends and a bad_line flag.
//
// From request to response an item passes the product register, the
// numerator register, the load of the four parallel restoring dividers,
// 35 divider stages (one quotient bit per stage), one saturation stage
// and the response register, which also takes the combinational choice
// of the two segment ends.
// Throughput is one item per cycle when not stalled. The whole pipeline
// advances only while the response register is empty or being drained,
// so a stalled receiver freezes every stage; nothing is lost or repeated.
// Reset clears all valid bits and loads the rectangle (0,0)-(1023,1023).
module line_to_rectangle_segment_unit (
   input  logic        clock,
   input  logic        reset,
   lrs_req_if.sink     req,
   lrs_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int Depth = lrs_pkg::PipeDepth;

   logic signed [15:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic [Depth-1:0]   vld_ff;
   logic               adv;
   lrs_pkg::rect_type  rect;
   lrs_pkg::ctl_type   ctl_ff [Depth];
   lrs_pkg::ctl_type   ctl_in;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         y1_ff <= '0;
         x2_ff <= 16'sd1023;
         y2_ff <= 16'sd1023;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr)
            lrs_pkg::AddrXFirst:  x1_ff <= csr_pwdata[15:0];
            lrs_pkg::AddrYFirst:  y1_ff <= csr_pwdata[15:0];
            lrs_pkg::AddrXSecond: x2_ff <= csr_pwdata[15:0];
            lrs_pkg::AddrYSecond: y2_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (csr_paddr)
         lrs_pkg::AddrXFirst:  csr_prdata = 32'(x1_ff);
         lrs_pkg::AddrYFirst:  csr_prdata = 32'(y1_ff);
         lrs_pkg::AddrXSecond: csr_prdata = 32'(x2_ff);
         lrs_pkg::AddrYSecond: csr_prdata = 32'(y2_ff);
         default:              csr_prdata = '0;
      endcase
   end

   assign rect.xl = (x1_ff < x2_ff) ? x1_ff : x2_ff;
   assign rect.xh = (x1_ff < x2_ff) ? x2_ff : x1_ff;
   assign rect.yl = (y1_ff < y2_ff) ? y1_ff : y2_ff;
   assign rect.yh = (y1_ff < y2_ff) ? y2_ff : y1_ff;

   // The pipeline moves when the response slot is free or is being taken.
   assign adv = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   logic signed [16:0] a, b;
   assign a = req.line_a;
   assign b = req.line_b;

   always_comb begin
      ctl_in.bad   = (a == 0) && (b == 0);
      ctl_in.horiz = (a == 0);
      ctl_in.vert  = (b == 0);
      ctl_in.use_l = (b != 0) && (rect.yl != rect.yh);
      ctl_in.use_r = ctl_in.use_l;
      ctl_in.use_t = (a != 0) && (rect.xl != rect.xh);
      ctl_in.use_b = ctl_in.use_t;
      ctl_in.rect  = rect;
   end

   // Stage 1: products.
   logic signed [33:0] pl_ff, pt_ff, pr_ff, pb_ff;
   logic signed [31:0] c1_ff;
   logic signed [16:0] a1_ff, b1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff <= 34'(a * rect.xl);
         pr_ff <= 34'(a * rect.xh);
         pt_ff <= 34'(b * rect.yl);
         pb_ff <= 34'(b * rect.yh);
         c1_ff <= req.line_c;
         a1_ff <= a;
         b1_ff <= b;
      end
   end

   // Stage 2: numerators -(c + p) split into sign and magnitude.
   lrs_pkg::div_job_type job_l, job_t, job_r, job_b;
   function automatic lrs_pkg::div_job_type mk(input logic signed [33:0] p,
         input logic signed [31:0] c, input logic signed [16:0] d);
      logic signed [34:0] n;
      lrs_pkg::div_job_type j;
      n = -(35'(c) + 35'(p));
      j.neg = (n < 0) != (d < 0) && n != 0;
      j.num = n < 0 ? 34'(-n) : 34'(n);
      j.den = d < 0 ? 17'(-d) : 17'(d);
      if (d == 0) j.den = 17'd1;
      return j;
   endfunction
   always_ff @(posedge clock) begin
      if (adv) begin
         job_l <= mk(pl_ff, c1_ff, b1_ff);
         job_r <= mk(pr_ff, c1_ff, b1_ff);
         job_t <= mk(pt_ff, c1_ff, a1_ff);
         job_b <= mk(pb_ff, c1_ff, a1_ff);
      end
   end

   logic signed [31:0] q_l, q_t, q_r, q_b;
   lrs_divider u_dl (.clock, .adv, .job_in(job_l), .quo_out(q_l));
   lrs_divider u_dt (.clock, .adv, .job_in(job_t), .quo_out(q_t));
   lrs_divider u_dr (.clock, .adv, .job_in(job_r), .quo_out(q_r));
   lrs_divider u_db (.clock, .adv, .job_in(job_b), .quo_out(q_b));

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < Depth; k++) ctl_ff[k] <= ctl_ff[k-1];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[Depth-2:0], req.valid};
   end

   logic [31:0] xs, ys, xe, ye;
   logic        bad;
   lrs_select u_sel (.ctl(ctl_ff[Depth-1]), .q_l, .q_t, .q_r, .q_b,
                     .xs, .ys, .xe, .ye, .bad);

   logic        rv_ff;
   logic [31:0] xs_ff, ys_ff, xe_ff, ye_ff;
   logic        bad_ff;
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (adv) rv_ff <= vld_ff[Depth-1];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         bad_ff <= bad;
         xs_ff  <= bad ? '0 : xs;
         ys_ff  <= bad ? '0 : ys;
         xe_ff  <= bad ? '0 : xe;
         ye_ff  <= bad ? '0 : ye;
      end
   end
   assign rsp.valid       = rv_ff;
   assign rsp.seg_x_start = xs_ff;
   assign rsp.seg_y_start = ys_ff;
   assign rsp.seg_x_end   = xe_ff;
   assign rsp.seg_y_end   = ye_ff;
   assign rsp.bad_line    = bad_ff;
endmodule

@@ rtl/core/lrs_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage. Gives n/d
// rounded half away, floor((2n+d)/2d), saturated to 32-bit signed.
module lrs_divider (
   input  logic                          clock,
   input  logic                          adv,
   input  lrs_pkg::div_job_type          job_in,
   output logic signed [lrs_pkg::OutWidth-1:0] quo_out
);
   localparam int Q = lrs_pkg::QuoWidth;
   localparam int DW = lrs_pkg::DenWidth + 1;
   localparam int OutWidth = lrs_pkg::OutWidth;

   logic [Q-1:0]    dvd_ff [Q+1];
   logic [Q-1:0]    quo_ff [Q+1];
   logic [DW-1:0]   rem_ff [Q+1];
   logic [DW-1:0]   den_ff [Q+1];
   logic            neg_ff [Q+1];
   logic signed [lrs_pkg::OutWidth-1:0] res_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dvd_ff[0] <= {job_in.num, 1'b0} + Q'(job_in.den);
         quo_ff[0] <= '0;
         rem_ff[0] <= '0;
         den_ff[0] <= {job_in.den, 1'b0};
         neg_ff[0] <= job_in.neg;
      end
   end

   for (genvar k = 0; k < Q; k++) begin : g_stage
      logic [DW:0] trial;
      assign trial = {rem_ff[k], dvd_ff[k][Q-1]} - {1'b0, den_ff[k]};
      always_ff @(posedge clock) begin
         if (adv) begin
            dvd_ff[k+1] <= {dvd_ff[k][Q-2:0], 1'b0};
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            if (!trial[DW]) begin
               rem_ff[k+1] <= trial[DW-1:0];
               quo_ff[k+1] <= {quo_ff[k][Q-2:0], 1'b1};
            end else begin
               rem_ff[k+1] <= {rem_ff[k][DW-2:0], dvd_ff[k][Q-1]};
               quo_ff[k+1] <= {quo_ff[k][Q-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (neg_ff[Q]) begin
            if (quo_ff[Q] > Q'(64'h8000_0000)) res_ff <= 32'sh8000_0000;
            else res_ff <= OutWidth'(-quo_ff[Q]);
         end else begin
            if (quo_ff[Q] > Q'(64'h7FFF_FFFF)) res_ff <= 32'sh7FFF_FFFF;
            else res_ff <= OutWidth'(quo_ff[Q]);
         end
      end
   end
   assign quo_out = res_ff;
endmodule

@@ rtl/core/lrs_select.sv @@
// Ranks the four crossings by x (ties by side order) and picks ends.
module lrs_select (
   input  lrs_pkg::ctl_type       ctl,
   input  logic signed [31:0]     q_l,
   input  logic signed [31:0]     q_t,
   input  logic signed [31:0]     q_r,
   input  logic signed [31:0]     q_b,
   output logic [31:0]            xs,
   output logic [31:0]            ys,
   output logic [31:0]            xe,
   output logic [31:0]            ye,
   output logic                   bad
);
   logic signed [31:0] px [4];
   logic signed [31:0] py [4];

   always_comb begin
      logic [1:0] s, e;
      logic [2:0] r;
      px[0] = 32'(ctl.rect.xl);
      py[0] = ctl.use_l ? q_l : 32'(ctl.rect.yl);
      px[1] = ctl.use_t ? q_t : 32'(ctl.rect.xl);
      py[1] = 32'(ctl.rect.yl);
      px[2] = 32'(ctl.rect.xh);
      py[2] = ctl.use_r ? q_r : 32'(ctl.rect.yh);
      px[3] = ctl.use_b ? q_b : 32'(ctl.rect.xh);
      py[3] = 32'(ctl.rect.yh);
      s = 2'd0;
      e = 2'd0;
      for (int i = 0; i < 4; i++) begin
         r = '0;
         for (int j = 0; j < 4; j++) begin
            if (j != i && (px[j] < px[i] || (px[j] == px[i] && j < i))) r = r + 3'd1;
         end
         if (r == 3'd1) s = 2'(i);
         if (r == 3'd2) e = 2'(i);
      end
      if (ctl.horiz) begin
         s = 2'd0;
         e = 2'd2;
      end else if (ctl.vert) begin
         s = 2'd1;
         e = 2'd3;
      end
      xs = px[s];
      ys = py[s];
      xe = px[e];
      ye = py[e];
   end

   assign bad = ctl.bad;
endmodule

@@ sim/tb_segment_checker.sv @@
module tb_segment_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [16:0] req_line_a,
   input  logic [16:0] req_line_b,
   input  logic [31:0] req_line_c,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_seg_x_start,
   input  logic [31:0] rsp_seg_y_start,
   input  logic [31:0] rsp_seg_x_end,
   input  logic [31:0] rsp_seg_y_end,
   input  logic        rsp_bad_line,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] xs;
      logic [31:0] ys;
      logic [31:0] xe;
      logic [31:0] ye;
      logic        bad;
   } segment_type;

   segment_type segments_due[$];
   logic signed [15:0] corner_x1, corner_y1, corner_x2, corner_y2;

   assign pending_count = segments_due.size();

   // Rounded quotient n/d, half away from zero, saturated to 32 bits.
   function automatic longint round_div(longint n, longint d);
      logic neg;
      longint un, ud, q;
      begin
         neg = (n < 0) != (d < 0);
         un = n < 0 ? -n : n;
         ud = d < 0 ? -d : d;
         q = (2 * un + ud) / (2 * ud);
         if (neg) begin
            if (q > 64'sd2147483648) q = 64'sd2147483648;
            return -q;
         end
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         return q;
      end
   endfunction

   function automatic segment_type clip_line(logic [16:0] ra, logic [16:0] rb,
                                             logic [31:0] rc);
      longint a, b, c, xl, xh, yl, yh;
      longint px[4], py[4];
      int s, e, r;
      segment_type seg;
      begin
         a = longint'($signed(ra));
         b = longint'($signed(rb));
         c = longint'($signed(rc));
         xl = corner_x1 < corner_x2 ? corner_x1 : corner_x2;
         xh = corner_x1 < corner_x2 ? corner_x2 : corner_x1;
         yl = corner_y1 < corner_y2 ? corner_y1 : corner_y2;
         yh = corner_y1 < corner_y2 ? corner_y2 : corner_y1;
         seg = '0;
         if (a == 0 && b == 0) begin
            seg.bad = 1'b1;
            return seg;
         end
         px[0] = xl; py[0] = yl;
         if (b != 0 && yl != yh) py[0] = round_div(-(c + a * xl), b);
         px[1] = xl; py[1] = yl;
         if (a != 0 && xl != xh) px[1] = round_div(-(c + b * yl), a);
         px[2] = xh; py[2] = yh;
         if (b != 0 && yl != yh) py[2] = round_div(-(c + a * xh), b);
         px[3] = xh; py[3] = yh;
         if (a != 0 && xl != xh) px[3] = round_div(-(c + b * yh), a);
         s = 0; e = 0;
         if (a == 0) begin
            s = 0; e = 2;
         end else if (b == 0) begin
            s = 1; e = 3;
         end else begin
            for (int i = 0; i < 4; i++) begin
               r = 0;
               for (int j = 0; j < 4; j++)
                  if (j != i && (px[j] < px[i] || (px[j] == px[i] && j < i))) r++;
               if (r == 1) s = i;
               if (r == 2) e = i;
            end
         end
         seg.xs = px[s][31:0];
         seg.ys = py[s][31:0];
         seg.xe = px[e][31:0];
         seg.ye = py[e][31:0];
         return seg;
      end
   endfunction

   always @(posedge clock) begin
      segment_type got, want;
      if (reset) begin
         corner_x1 <= 16'sd0;
         corner_y1 <= 16'sd0;
         corner_x2 <= 16'sd1023;
         corner_y2 <= 16'sd1023;
         fail_count <= 0;
         segments_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr)
               lrs_pkg::AddrXFirst:  corner_x1 <= csr_pwdata[15:0];
               lrs_pkg::AddrYFirst:  corner_y1 <= csr_pwdata[15:0];
               lrs_pkg::AddrXSecond: corner_x2 <= csr_pwdata[15:0];
               lrs_pkg::AddrYSecond: corner_y2 <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            segments_due.push_back(clip_line(req_line_a, req_line_b, req_line_c));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_seg_x_start, rsp_seg_y_start, rsp_seg_x_end, rsp_seg_y_end,
                   rsp_bad_line};
            if (segments_due.size() == 0) begin
               if (fail_count < 10) $display("unexpected segment %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = segments_due.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("segment mismatch: expected %h %h %h %h %b, got %h %h %h %h %b",
                              want.xs, want.ys, want.xe, want.ye, want.bad,
                              got.xs, got.ys, got.xe, got.ye, got.bad);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ sim/tb_line_to_rectangle_segment_unit.sv @@
module tb_line_to_rectangle_segment_unit;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   int fail_count, pending_count;
   int send_idle_pct, take_idle_pct;
   int lines_sent;

   lrs_req_if req ();
   lrs_rsp_if rsp ();

   always #4 clock = ~clock;

   line_to_rectangle_segment_unit u_top (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   tb_segment_checker u_checker (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_line_a(req.line_a),
      .req_line_b(req.line_b), .req_line_c(req.line_c),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_seg_x_start(rsp.seg_x_start), .rsp_seg_y_start(rsp.seg_y_start),
      .rsp_seg_x_end(rsp.seg_x_end), .rsp_seg_y_end(rsp.seg_y_end),
      .rsp_bad_line(rsp.bad_line),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .fail_count, .pending_count
   );

   // The receiver stalls at random with the current percentage, redrawn every cycle.
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= take_idle_pct);
   end

   // One APB write: a setup phase, then an access phase.
   task automatic write_corner(input logic [3:0] addr, input logic signed [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= {{16{value[15]}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_rectangle(input logic signed [15:0] x1, y1, x2, y2);
      write_corner(lrs_pkg::AddrXFirst, x1);
      write_corner(lrs_pkg::AddrYFirst, y1);
      write_corner(lrs_pkg::AddrXSecond, x2);
      write_corner(lrs_pkg::AddrYSecond, y2);
   endtask

   // Presents one line and holds it until the block takes it. The sender may
   // idle first; valid is only lowered when no line follows directly.
   task automatic send_line(input logic [16:0] a, b, input logic [31:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.line_a <= a;
      req.line_b <= b;
      req.line_c <= c;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      lines_sent++;
   endtask

   // The first edge lets the checker record the last accepted line.
   task automatic wait_drained();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // Coefficients mostly small so the crossings land near the rectangle, with
   // full-range and zero values mixed in to reach saturation and the axis cases.
   task automatic send_random_line();
      logic [16:0] a, b;
      logic [31:0] c;
      int pick;
      pick = $urandom_range(9);
      a = (pick < 2) ? 17'($urandom) : 17'($signed($urandom_range(400)) - 200);
      b = (pick == 2 || pick == 3) ? 17'($urandom) : 17'($signed($urandom_range(400)) - 200);
      if (pick == 4) a = '0;
      if (pick == 5) b = '0;
      c = (pick > 6) ? $urandom : 32'($signed($urandom_range(400000)) - 200000);
      send_line(a, b, c);
   endtask

   initial begin
      req.valid = 1'b0;
      req.line_a = '0;
      req.line_b = '0;
      req.line_c = '0;
      send_idle_pct = 0;
      take_idle_pct = 0;
      lines_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines against the reset rectangle: both bad-line forms, the
      // horizontal and vertical cases, and extreme coefficients that saturate.
      send_line(17'd0, 17'd0, 32'd0);
      send_line(17'd0, 17'd0, 32'h8000_0000);
      send_line(17'd0, 17'd1, -32'sd500);
      send_line(17'd1, 17'd0, -32'sd500);
      send_line(17'd1, -17'sd1, 32'd0);
      send_line(17'd1, 17'd1, -32'sd1023);
      send_line(17'h10000, 17'h0FFFF, 32'h7FFF_FFFF);
      send_line(17'h0FFFF, 17'h10000, 32'h8000_0000);
      send_line(17'd1, 17'd1, 32'h7FFF_FFFF);
      send_line(17'd0, 17'h10000, 32'h8000_0000);
      send_line(17'h10000, 17'd0, 32'h7FFF_FFFF);
      send_line(17'd2, 17'd3, 32'd7);
      send_line(17'd2, -17'sd2, -32'sd1);
      wait_drained();

      // Swapped and degenerate corners: zero-width and zero-height sides give corners.
      set_rectangle(16'sd100, 16'sd100, 16'sd100, -16'sd50);
      send_line(17'd3, 17'd5, -32'sd77);
      send_line(17'd0, 17'd5, -32'sd77);
      send_line(17'd3, 17'd0, -32'sd77);
      wait_drained();
      set_rectangle(16'sd7, -16'sd9, -16'sd20, -16'sd9);
      send_line(17'd3, 17'd5, 32'd77);
      send_line(17'd0, 17'd5, 32'd77);
      send_line(17'd3, 17'd0, 32'd77);
      wait_drained();

      // Random phases across several rectangles, extremes among them.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_rectangle(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
            1: set_rectangle(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
            2: set_rectangle(16'sd0, 16'sd0, 16'sd1023, 16'sd1023);
            default: set_rectangle(16'($urandom), 16'($urandom),
                                   16'($signed($urandom_range(2000)) - 1000),
                                   16'($signed($urandom_range(2000)) - 1000));
         endcase
         send_idle_pct = (phase < 2) ? 12 : (phase < 4) ? 83 : 0;
         take_idle_pct = (phase < 2) ? 83 : (phase < 4) ? 12 : 0;
         repeat (88) send_random_line();
         wait_drained();
      end
   end

   // Verdict once all stimulus has drained.
   initial begin
      wait (lines_sent >= 19 + 6 * 88);
      @(posedge clock);
      wait (pending_count == 0);
      repeat (60) @(posedge clock);
      $display("Sent %0d lines over nine rectangles, including degenerate and full-range ones,",
               lines_sent);
      $display("with sender and receiver stalls in both proportions and none.");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule

@@ files.f @@
rtl/core/lrs_pkg.sv
rtl/core/lrs_if.sv
rtl/core/lrs_divider.sv
rtl/core/lrs_select.sv
rtl/core/line_to_rectangle_segment_unit.sv
sim/tb_segment_checker.sv
sim/tb_line_to_rectangle_segment_unit.sv
